// File: hdl/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared sizes, hash constants and helpers of the flow tag consistency checker.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SLOT_W      = IDX_W + 1;
    localparam int SLOT_COUNT  = 2 * TABLE_DEPTH;

    localparam int IN_DATA_W   = 184;
    localparam int OUT_DATA_W  = 200;

    localparam logic [15:0] TAG_BYTES    = 16'd8;
    localparam logic [15:0] OFFSET_RESET = 16'd40;

    localparam logic [31:0] HASH_A_LO = 32'h7F4A7C15;
    localparam logic [31:0] HASH_A_HI = 32'h9E3779B9;
    localparam logic [31:0] HASH_B_LO = 32'h27D4EB4F;
    localparam logic [31:0] HASH_B_HI = 32'hC2B2AE3D;
    localparam logic [63:0] HASH_B_ADD = 64'h632BE59BD9B4E019;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// File: hdl/flow_tag_consistency_checker.sv
// ----------------------------------------------------------------------------
// flow_tag_consistency_checker
// Exact-match flow table that tracks the last tag of each flow and counts
// tag changes, packets and too-short packets.
// ----------------------------------------------------------------------------
// Usage: packets enter on the s_axis channel (5-tuple, length, tag) and one
// result leaves on m_axis for each packet. The tag offset is set through
// i_cfg_wen / i_cfg_wdata; the user must write it only while the block is
// idle, the block does not enforce this. s_axis_tready is high only while
// the block is idle; one packet is worked on at a time. A short packet
// shows its result the cycle after acceptance. Any other packet runs the
// hash on one shared 32x32 multiplier (6 products), then a mix step, then
// probes the lookup index: each slot is read and checked, the entry of an
// occupied slot is compared, and the probe moves to the next slot until an
// empty slot or a match is found; the result then shows in S_OUT.
// The result is held in m_axis_tdata until m_axis_tready; the block takes no
// new packet before the result is taken, and can take one from the cycle after.
// After reset the lookup index is swept to zero, one slot per cycle, over all
// 2 * TABLE_DEPTH (131072) slots with s_axis_tready low; configuration
// writes are taken during the sweep. The flow stores are not cleared: only
// entries below the fill count are ever compared.
// ----------------------------------------------------------------------------
module flow_tag_consistency_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wen,
    input  logic [15:0]                      i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // src_addr, dst_addr, src_port, dst_port, protocol, packet_length, tag
    input  logic [fcc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // flow_index, new_flow, tag_changed, short_packet, table_full,
    // flow_packets, flow_breaks, broken_flows_total, broken_packets_total,
    // short_total, flows_total, zero pad
    output logic [fcc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import fcc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_MIX, S_SLOT_RD, S_SLOT_CHK, S_ENT_CHK, S_OUT
    } t_state;

    t_state r_state;

    // memories
    logic [SLOT_W-1:0] slot_mem [SLOT_COUNT];
    logic [103:0]      key_mem  [TABLE_DEPTH];
    logic [63:0]       tag_mem  [TABLE_DEPTH];
    logic [31:0]       pk_mem   [TABLE_DEPTH];
    logic [31:0]       br_mem   [TABLE_DEPTH];

    logic [15:0]       r_offset;
    logic [SLOT_W-1:0] r_clr;
    logic [SLOT_W-1:0] r_used;
    logic [31:0]       r_short_cnt;
    logic [31:0]       r_bflow_cnt;
    logic [31:0]       r_bpkt_cnt;

    logic [63:0]       r_addrs;
    logic [39:0]       r_ports;
    logic [63:0]       r_bp;
    logic [63:0]       r_tag;
    logic [2:0]        r_step;
    logic [63:0]       r_prod;
    logic [63:0]       r_h1;
    logic [63:0]       r_h2;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_slot_q;
    logic [SLOT_W-1:0] r_ent;
    logic [103:0]      r_key_q;
    logic [63:0]       r_tag_q;
    logic [31:0]       r_pk_q;
    logic [31:0]       r_br_q;

    // result
    logic [15:0] r_fidx;
    logic        r_new;
    logic        r_chg;
    logic        r_short;
    logic        r_full;
    logic [31:0] r_pk;
    logic [31:0] r_br;

    logic [31:0] w_op_a;
    logic [31:0] w_op_b;
    logic [63:0] w_h;
    logic [63:0] w_hmix;
    logic [16:0] w_need;
    logic        w_accept;
    logic [SLOT_W-1:0] w_ent;
    logic        w_match;
    logic        w_tag_diff;
    logic [31:0] w_pk_n;
    logic [31:0] w_br_n;

    // entry write port
    logic              w_ent_we;
    logic [IDX_W-1:0]  w_ent_waddr;
    logic [63:0]       w_tag_wd;
    logic [31:0]       w_pk_wd;
    logic [31:0]       w_br_wd;

    // slot write port
    logic              w_slot_we;
    logic [SLOT_W-1:0] w_slot_waddr;
    logic [SLOT_W-1:0] w_slot_wd;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_need = {1'b0, r_offset} + {1'b0, TAG_BYTES};

    // one shared multiplier, operands picked by the hash step
    always_comb begin
        unique case (r_step)
            3'd0:    begin w_op_a = r_addrs[31:0];  w_op_b = HASH_A_LO; end
            3'd1:    begin w_op_a = r_addrs[31:0];  w_op_b = HASH_A_HI; end
            3'd2:    begin w_op_a = r_addrs[63:32]; w_op_b = HASH_A_LO; end
            3'd3:    begin w_op_a = r_bp[31:0];     w_op_b = HASH_B_LO; end
            3'd4:    begin w_op_a = r_bp[31:0];     w_op_b = HASH_B_HI; end
            default: begin w_op_a = r_bp[63:32];    w_op_b = HASH_B_LO; end
        endcase
    end

    assign w_h    = r_h1 ^ r_h2;
    assign w_hmix = w_h ^ (w_h >> 29);

    assign w_ent      = r_slot_q - SLOT_W'(1);
    assign w_match    = (r_ent < r_used) && (r_key_q == {r_addrs, r_ports});
    assign w_tag_diff = (r_tag_q != r_tag);
    assign w_pk_n     = sat_inc(r_pk_q);
    assign w_br_n     = w_tag_diff ? sat_inc(r_br_q) : r_br_q;

    always_comb begin
        w_ent_we     = 1'b0;
        w_ent_waddr  = r_ent[IDX_W-1:0];
        w_tag_wd     = r_tag;
        w_pk_wd      = w_pk_n;
        w_br_wd      = w_br_n;
        w_slot_we    = 1'b0;
        w_slot_waddr = r_slot;
        w_slot_wd    = r_used + SLOT_W'(1);
        if (r_state == S_CLEAR) begin
            w_slot_we    = 1'b1;
            w_slot_waddr = r_clr;
            w_slot_wd    = '0;
        end else if (r_state == S_SLOT_CHK && r_slot_q == '0 &&
                     r_used != SLOT_W'(TABLE_DEPTH)) begin
            // new flow takes the next free entry
            w_slot_we   = 1'b1;
            w_ent_we    = 1'b1;
            w_ent_waddr = r_used[IDX_W-1:0];
            w_pk_wd     = 32'd1;
            w_br_wd     = 32'd0;
        end else if (r_state == S_ENT_CHK && w_match) begin
            w_ent_we = 1'b1;
        end
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            slot_mem[w_slot_waddr] <= w_slot_wd;
        end
        if (r_state == S_SLOT_RD) begin
            r_slot_q <= slot_mem[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            key_mem[w_ent_waddr] <= {r_addrs, r_ports};
            tag_mem[w_ent_waddr] <= w_tag_wd;
            pk_mem[w_ent_waddr]  <= w_pk_wd;
            br_mem[w_ent_waddr]  <= w_br_wd;
        end
        if (r_state == S_SLOT_CHK) begin
            r_key_q <= key_mem[w_ent[IDX_W-1:0]];
            r_tag_q <= tag_mem[w_ent[IDX_W-1:0]];
            r_pk_q  <= pk_mem[w_ent[IDX_W-1:0]];
            r_br_q  <= br_mem[w_ent[IDX_W-1:0]];
        end
    end

    // payload and hash datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addrs <= {s_axis_tdata[31:0], s_axis_tdata[63:32]};
            r_ports <= s_axis_tdata[103:64];
            r_bp    <= {24'd0, s_axis_tdata[79:64], s_axis_tdata[95:80],
                        s_axis_tdata[103:96]} + HASH_B_ADD;
            r_tag   <= s_axis_tdata[183:120];
            r_h1    <= '0;
            r_h2    <= '0;
        end
        if (r_state == S_HASH) begin
            r_prod <= w_op_a * w_op_b;
            // fold in the product of the previous step
            unique case (r_step)
                3'd1:    r_h1 <= r_h1 + r_prod;
                3'd2,
                3'd3:    r_h1 <= r_h1 + {r_prod[31:0], 32'd0};
                3'd4:    r_h2 <= r_h2 + r_prod;
                3'd5,
                3'd6:    r_h2 <= r_h2 + {r_prod[31:0], 32'd0};
                default: ;
            endcase
        end
        if (r_state == S_SLOT_CHK) begin
            r_ent <= w_ent;
        end
    end

    // sequencer, counters and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_offset    <= OFFSET_RESET;
            r_clr       <= '0;
            r_used      <= '0;
            r_short_cnt <= '0;
            r_bflow_cnt <= '0;
            r_bpkt_cnt  <= '0;
            r_step      <= '0;
            r_slot      <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_offset <= i_cfg_wdata;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SLOT_W'(1);
                    if (r_clr == SLOT_W'(SLOT_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_fidx  <= '0;
                        r_new   <= 1'b0;
                        r_chg   <= 1'b0;
                        r_full  <= 1'b0;
                        r_pk    <= '0;
                        r_br    <= '0;
                        r_step  <= '0;
                        if ({1'b0, s_axis_tdata[119:104]} < w_need) begin
                            r_short     <= 1'b1;
                            r_short_cnt <= sat_inc(r_short_cnt);
                            r_state     <= S_OUT;
                        end else begin
                            r_short <= 1'b0;
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd6) begin
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_slot  <= w_hmix[SLOT_W-1:0];
                    r_state <= S_SLOT_RD;
                end
                S_SLOT_RD: begin
                    r_state <= S_SLOT_CHK;
                end
                S_SLOT_CHK: begin
                    if (r_slot_q == '0) begin
                        if (r_used == SLOT_W'(TABLE_DEPTH)) begin
                            r_full <= 1'b1;
                        end else begin
                            r_fidx <= 16'(r_used[IDX_W-1:0]);
                            r_new  <= 1'b1;
                            r_pk   <= 32'd1;
                            r_used <= r_used + SLOT_W'(1);
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_ENT_CHK;
                    end
                end
                S_ENT_CHK: begin
                    if (w_match) begin
                        r_fidx <= 16'(r_ent[IDX_W-1:0]);
                        r_chg  <= w_tag_diff;
                        r_pk   <= w_pk_n;
                        r_br   <= w_br_n;
                        if (w_tag_diff) begin
                            r_bpkt_cnt <= sat_inc(r_bpkt_cnt);
                            if (r_br_q == '0) begin
                                r_bflow_cnt <= sat_inc(r_bflow_cnt);
                            end
                        end
                        r_state <= S_OUT;
                    end else begin
                        // linear probe, wraps over the slot range
                        r_slot  <= r_slot + SLOT_W'(1);
                        r_state <= S_SLOT_RD;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = {3'd0, 17'(r_used), r_short_cnt, r_bpkt_cnt, r_bflow_cnt,
                           r_br, r_pk, r_full, r_short, r_chg, r_new, r_fidx};

endmodule
